/* design/mbap_pkg.sv */
// shared types and constants of the modbus tcp framing unit
`timescale 1ns / 1ps

package mbap_pkg;

    localparam int FRAME_BUFFER_BYTES = 264;
    localparam int HDR_BYTES          = 8;
    localparam int LEN_OFFSET         = 2;
    localparam int COUNT_OFFSET       = 6;

    localparam logic [15:0] TX_PAYLOAD_MAX = 16'(FRAME_BUFFER_BYTES - HDR_BYTES);
    localparam logic [8:0]  RX_LIMIT_MAX   = 9'd256;
    localparam logic [8:0]  RX_LIMIT_RESET = 9'd256;

    typedef enum logic [1:0] {
        KIND_TX_START = 2'd0,
        KIND_TX_BYTE  = 2'd1,
        KIND_RX_BYTE  = 2'd2
    } item_kind_t;

    typedef enum logic [1:0] {
        OUT_TX_BYTE = 2'd0,
        OUT_RX_BYTE = 2'd1,
        OUT_STATUS  = 2'd2
    } out_kind_t;

    typedef enum logic [2:0] {
        ST_GOOD     = 3'd0,
        ST_SHORT    = 3'd1,
        ST_PROTOCOL = 3'd2,
        ST_LENGTH   = 3'd3,
        ST_ID       = 3'd4,
        ST_OVERFLOW = 3'd5
    } status_t;

    typedef enum logic {
        CFG_SERVER_MODE    = 1'b0,
        CFG_MAX_RX_PAYLOAD = 1'b1
    } cfg_index_t;

    typedef struct packed {
        out_kind_t   out_kind;
        logic [7:0]  out_byte;
        logic [7:0]  rx_unit;
        logic [7:0]  rx_function;
        status_t     status;
        logic [8:0]  delivered_count;
    } res_t;

    typedef struct packed {
        logic        pay_valid;
        logic [7:0]  pay_byte;
        logic        st_valid;
        status_t     status;
        logic [7:0]  unit;
        logic [7:0]  func;
        logic [8:0]  delivered;
        logic        capture;
        logic [15:0] capture_id;
    } rx_res_t;

endpackage

/* design/mbap_item_if.sv */
// input item channel
`timescale 1ns / 1ps

interface mbap_item_if;
    logic        valid;
    logic        ready;
    logic [1:0]  kind;
    logic [7:0]  unit_id;
    logic [7:0]  function_code;
    logic [15:0] payload_length;
    logic        repeat_request;
    logic [7:0]  data_byte;
    logic        frame_end;

    modport source (
        output valid, kind, unit_id, function_code, payload_length,
               repeat_request, data_byte, frame_end,
        input  ready
    );

    modport sink (
        input  valid, kind, unit_id, function_code, payload_length,
               repeat_request, data_byte, frame_end,
        output ready
    );
endinterface

/* design/mbap_result_if.sv */
// result item channel
`timescale 1ns / 1ps

interface mbap_result_if;
    logic       valid;
    logic       ready;
    logic [1:0] out_kind;
    logic [7:0] out_byte;
    logic [7:0] rx_unit;
    logic [7:0] rx_function;
    logic [2:0] status;
    logic [8:0] delivered_count;
    logic       run_last;

    modport source (
        output valid, out_kind, out_byte, rx_unit, rx_function, status,
               delivered_count, run_last,
        input  ready
    );

    modport sink (
        input  valid, out_kind, out_byte, rx_unit, rx_function, status,
               delivered_count, run_last,
        output ready
    );
endinterface

/* design/mbap_cfg_if.sv */
// configuration write channel
`timescale 1ns / 1ps

interface mbap_cfg_if;
    logic       valid;
    logic       ready;
    logic       index;
    logic [8:0] data;

    modport source (
        output valid, index, data,
        input  ready
    );

    modport sink (
        input  valid, index, data,
        output ready
    );
endinterface

/* design/mbap_rx_parse.sv */
// receive frame parser: header capture, payload limit and frame checks
`timescale 1ns / 1ps

module mbap_rx_parse
    import mbap_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        step,
    input  logic [7:0]  data_byte,
    input  logic        frame_end,
    input  logic        server_mode,
    input  logic [8:0]  rx_limit,
    input  logic [15:0] tid,
    output rx_res_t     res
);

    logic [15:0] cnt_reg;
    logic [15:0] trans_reg;
    logic        proto_reg;
    logic [15:0] len_reg;
    logic [7:0]  unit_reg;
    logic [7:0]  func_reg;
    logic [8:0]  deliv_reg;

    logic [15:0] cnt_upd;
    logic [15:0] trans_upd;
    logic        proto_upd;
    logic [15:0] len_upd;
    logic [7:0]  unit_upd;
    logic [7:0]  func_upd;
    logic [8:0]  deliv_upd;
    logic [8:0]  limit_eff;
    logic        hdr_pos;
    logic        deliver;
    status_t     st;

    assign limit_eff = (rx_limit > RX_LIMIT_MAX) ? RX_LIMIT_MAX : rx_limit;
    assign hdr_pos   = cnt_reg < 16'(HDR_BYTES);
    assign deliver   = !hdr_pos && (deliv_reg < limit_eff);
    assign deliv_upd = deliv_reg + {8'd0, deliver};
    assign cnt_upd   = (cnt_reg == 16'hFFFF) ? cnt_reg : cnt_reg + 16'd1;

    always_comb
    begin
        trans_upd = trans_reg;
        proto_upd = proto_reg;
        len_upd   = len_reg;
        unit_upd  = unit_reg;
        func_upd  = func_reg;
        if (hdr_pos)
        begin
            unique case (cnt_reg[2:0])
                3'd0: trans_upd = {data_byte, trans_reg[7:0]};
                3'd1: trans_upd = {trans_reg[15:8], data_byte};
                3'd2, 3'd3: proto_upd = proto_reg | (data_byte != 8'd0);
                3'd4: len_upd = {data_byte, len_reg[7:0]};
                3'd5: len_upd = {len_reg[15:8], data_byte};
                3'd6: unit_upd = data_byte;
                3'd7: func_upd = data_byte;
                default: unit_upd = unit_reg;
            endcase
        end
    end

    // checks in priority order
    always_comb
    begin
        priority if (cnt_upd < 16'(HDR_BYTES))
            st = ST_SHORT;
        else if (proto_upd)
            st = ST_PROTOCOL;
        else if (len_upd != cnt_upd - 16'(COUNT_OFFSET))
            st = ST_LENGTH;
        else if (!server_mode && (tid != trans_upd))
            st = ST_ID;
        else
            st = ST_GOOD;
    end

    always_comb
    begin
        res.pay_valid  = deliver;
        res.pay_byte   = data_byte;
        res.st_valid   = frame_end;
        res.status     = st;
        res.unit       = (st == ST_GOOD) ? unit_upd : 8'd0;
        res.func       = (st == ST_GOOD) ? func_upd : 8'd0;
        res.delivered  = (st == ST_GOOD) ? deliv_upd : 9'd0;
        res.capture    = frame_end && server_mode && (st == ST_GOOD);
        res.capture_id = trans_upd;
    end

    // frame state clears after each status
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg   <= '0;
            trans_reg <= '0;
            proto_reg <= 1'b0;
            len_reg   <= '0;
            unit_reg  <= '0;
            func_reg  <= '0;
            deliv_reg <= '0;
        end
        else if (step)
        begin
            if (frame_end)
            begin
                cnt_reg   <= '0;
                trans_reg <= '0;
                proto_reg <= 1'b0;
                len_reg   <= '0;
                unit_reg  <= '0;
                func_reg  <= '0;
                deliv_reg <= '0;
            end
            else
            begin
                cnt_reg   <= cnt_upd;
                trans_reg <= trans_upd;
                proto_reg <= proto_upd;
                len_reg   <= len_upd;
                unit_reg  <= unit_upd;
                func_reg  <= func_upd;
                deliv_reg <= deliv_upd;
            end
        end
    end

endmodule

/* design/mbap_frame_codec_unit.sv */
// Modbus TCP framing unit: MBAP header build on transmit, frame parse and check on receive.
// An input item is taken into an input register and, once the result register is free,
// turned into a bundle of results there; a new input item can be taken every cycle
// while the result channel keeps up. The result channel carries one result per cycle
// while the receiver is ready, so a transmit start gives it 8 results (header bytes) or
// 1 (overflow status), a transmit payload byte 1, and a received byte 0 to 2 (payload
// byte, then status on frame end); the input channel stalls once the input register
// holds an item behind a bundle that is still being sent.
// Configuration writes are taken at once and apply from the next cycle on, also to an
// item still waiting in the input register.
`timescale 1ns / 1ps

module mbap_frame_codec_unit
    import mbap_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    mbap_item_if.sink     item,
    mbap_result_if.source result,
    mbap_cfg_if.sink      cfg
);

    // configuration
    logic        server_mode_reg;
    logic [8:0]  max_rx_reg;

    // input register
    logic        s1_valid_reg;
    logic [1:0]  s1_kind_reg;
    logic [7:0]  s1_unit_reg;
    logic [7:0]  s1_func_reg;
    logic [15:0] s1_plen_reg;
    logic        s1_rep_reg;
    logic [7:0]  s1_byte_reg;
    logic        s1_fend_reg;

    logic [15:0] tid_reg;
    logic [15:0] tid_next;

    // result bundle
    logic            bnd_valid_reg;
    logic [2:0]      bnd_idx_reg;
    logic [3:0]      bnd_cnt_reg;
    logic            bnd_hdr_reg;
    logic [7:0][7:0] bnd_bytes_reg;
    res_t            bnd_r0_reg;
    res_t            bnd_r1_reg;

    logic [3:0]      bnd_cnt_next;
    logic            bnd_hdr_next;
    logic [7:0][7:0] bnd_bytes_next;
    res_t            bnd_r0_next;
    res_t            bnd_r1_next;

    logic        in_fire;
    logic        out_fire;
    logic        bnd_last;
    logic        bundle_free;
    logic        advance;
    logic        rx_step;
    logic        overflow;
    logic [15:0] tx_len;
    rx_res_t     rx_res;
    res_t        pay_res;
    res_t        st_res;
    res_t        cur_res;

    assign in_fire     = item.valid && item.ready;
    assign out_fire    = result.valid && result.ready;
    assign bnd_last    = {1'b0, bnd_idx_reg} == (bnd_cnt_reg - 4'd1);
    assign bundle_free = !bnd_valid_reg || (out_fire && bnd_last);
    assign advance     = s1_valid_reg && bundle_free;
    assign item.ready  = !s1_valid_reg || advance;
    assign cfg.ready   = 1'b1;
    assign rx_step     = advance && (s1_kind_reg == KIND_RX_BYTE);

    mbap_rx_parse u_rx_parse (
        .clk         (clk),
        .rst_n       (rst_n),
        .step        (rx_step),
        .data_byte   (s1_byte_reg),
        .frame_end   (s1_fend_reg),
        .server_mode (server_mode_reg),
        .rx_limit    (max_rx_reg),
        .tid         (tid_reg),
        .res         (rx_res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            server_mode_reg <= 1'b0;
            max_rx_reg      <= RX_LIMIT_RESET;
        end
        else if (cfg.valid && cfg.ready)
        begin
            unique case (cfg_index_t'(cfg.index))
                CFG_SERVER_MODE:    server_mode_reg <= cfg.data[0];
                CFG_MAX_RX_PAYLOAD: max_rx_reg      <= cfg.data;
                default:            max_rx_reg      <= max_rx_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (in_fire)
            s1_valid_reg <= 1'b1;
        else if (advance)
            s1_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_kind_reg <= item.kind;
            s1_unit_reg <= item.unit_id;
            s1_func_reg <= item.function_code;
            s1_plen_reg <= item.payload_length;
            s1_rep_reg  <= item.repeat_request;
            s1_byte_reg <= item.data_byte;
            s1_fend_reg <= item.frame_end;
        end
    end

    assign overflow = s1_plen_reg > TX_PAYLOAD_MAX;
    assign tx_len   = s1_plen_reg + 16'(LEN_OFFSET);

    always_comb
    begin
        pay_res                 = '0;
        pay_res.out_kind        = OUT_RX_BYTE;
        pay_res.out_byte        = rx_res.pay_byte;
        st_res                  = '0;
        st_res.out_kind         = OUT_STATUS;
        st_res.status           = rx_res.status;
        st_res.rx_unit          = rx_res.unit;
        st_res.rx_function      = rx_res.func;
        st_res.delivered_count  = rx_res.delivered;

        tid_next       = tid_reg;
        bnd_cnt_next   = 4'd0;
        bnd_hdr_next   = 1'b0;
        bnd_bytes_next = '0;
        bnd_r0_next    = '0;
        bnd_r1_next    = '0;

        unique case (s1_kind_reg)
            KIND_TX_START:
            begin
                if (!server_mode_reg && !s1_rep_reg)
                    tid_next = tid_reg + 16'd1;
                if (overflow)
                begin
                    bnd_cnt_next       = 4'd1;
                    bnd_r0_next.out_kind = OUT_STATUS;
                    bnd_r0_next.status   = ST_OVERFLOW;
                end
                else
                begin
                    bnd_cnt_next      = 4'(HDR_BYTES);
                    bnd_hdr_next      = 1'b1;
                    bnd_bytes_next[0] = tid_next[15:8];
                    bnd_bytes_next[1] = tid_next[7:0];
                    bnd_bytes_next[4] = tx_len[15:8];
                    bnd_bytes_next[5] = tx_len[7:0];
                    bnd_bytes_next[6] = s1_unit_reg;
                    bnd_bytes_next[7] = s1_func_reg;
                end
            end
            KIND_TX_BYTE:
            begin
                bnd_cnt_next         = 4'd1;
                bnd_r0_next.out_kind = OUT_TX_BYTE;
                bnd_r0_next.out_byte = s1_byte_reg;
            end
            KIND_RX_BYTE:
            begin
                if (rx_res.capture)
                    tid_next = rx_res.capture_id;
                if (rx_res.pay_valid)
                begin
                    bnd_r0_next = pay_res;
                    bnd_r1_next = st_res;
                    bnd_cnt_next = rx_res.st_valid ? 4'd2 : 4'd1;
                end
                else if (rx_res.st_valid)
                begin
                    bnd_r0_next  = st_res;
                    bnd_cnt_next = 4'd1;
                end
            end
            default: bnd_cnt_next = 4'd0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            tid_reg <= '0;
        else if (advance)
            tid_reg <= tid_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bnd_valid_reg <= 1'b0;
            bnd_idx_reg   <= '0;
            bnd_cnt_reg   <= '0;
            bnd_hdr_reg   <= 1'b0;
        end
        else if (advance)
        begin
            bnd_valid_reg <= bnd_cnt_next != 4'd0;
            bnd_idx_reg   <= '0;
            bnd_cnt_reg   <= bnd_cnt_next;
            bnd_hdr_reg   <= bnd_hdr_next;
        end
        else if (out_fire)
        begin
            if (bnd_last)
                bnd_valid_reg <= 1'b0;
            else
                bnd_idx_reg <= bnd_idx_reg + 3'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            bnd_bytes_reg <= bnd_bytes_next;
            bnd_r0_reg    <= bnd_r0_next;
            bnd_r1_reg    <= bnd_r1_next;
        end
    end

    always_comb
    begin
        if (bnd_hdr_reg)
        begin
            cur_res          = '0;
            cur_res.out_kind = OUT_TX_BYTE;
            cur_res.out_byte = bnd_bytes_reg[bnd_idx_reg];
        end
        else if (bnd_idx_reg[0])
            cur_res = bnd_r1_reg;
        else
            cur_res = bnd_r0_reg;
    end

    assign result.valid           = bnd_valid_reg;
    assign result.out_kind        = cur_res.out_kind;
    assign result.out_byte        = cur_res.out_byte;
    assign result.rx_unit         = cur_res.rx_unit;
    assign result.rx_function     = cur_res.rx_function;
    assign result.status          = cur_res.status;
    assign result.delivered_count = cur_res.delivered_count;
    assign result.run_last        = bnd_last;

`ifndef SYNTHESIS
    a_idx_in_bundle: assert property (@(posedge clk) disable iff (!rst_n)
        bnd_valid_reg |-> ({1'b0, bnd_idx_reg} < bnd_cnt_reg))
        else $error("bundle index past its count");

    a_hdr_count: assert property (@(posedge clk) disable iff (!rst_n)
        (bnd_valid_reg && bnd_hdr_reg) |-> (bnd_cnt_reg == 4'(HDR_BYTES)))
        else $error("header bundle without eight bytes");

    a_status_last: assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && result.out_kind == OUT_STATUS) |-> result.run_last)
        else $error("status not last in its bundle");

    a_tid_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !advance |=> $stable(tid_reg))
        else $error("transaction id changed without an item");
`endif

endmodule

/* tb/tb_top.sv */
// testbench for the modbus tcp framing unit: directed and random items checked against a predictor
`timescale 1ns / 1ps

module tb_top;
    import mbap_pkg::*;

    localparam logic [1:0] KIND_UNUSED = 2'd3;

    typedef struct {
        logic [1:0]  kind;
        logic [7:0]  unit;
        logic [7:0]  func;
        logic [15:0] plen;
        logic        rep;
        logic [7:0]  data;
        logic        fend;
    } frame_item_t;

    typedef struct {
        out_kind_t  kind;
        logic [7:0] data;
        logic [7:0] unit;
        logic [7:0] func;
        status_t    status;
        logic [8:0] count;
        logic       last;
    } codec_out_t;

    typedef enum int {
        FLAW_NONE,
        FLAW_SHORT,
        FLAW_PROTOCOL,
        FLAW_LENGTH,
        FLAW_ID
    } frame_flaw_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    mbap_item_if   item_ch();
    mbap_result_if result_ch();
    mbap_cfg_if    cfg_ch();

    mbap_frame_codec_unit dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item_ch),
        .result (result_ch),
        .cfg    (cfg_ch)
    );

    // predictor copy of configuration and state
    logic        cfg_server   = 1'b0;
    logic [8:0]  cfg_rx_limit = RX_LIMIT_RESET;
    logic [15:0] txn_id       = '0;
    logic [15:0] rx_count     = '0;
    logic [15:0] rx_txn       = '0;
    logic [15:0] rx_len       = '0;
    logic        rx_proto_bad = 1'b0;
    logic [7:0]  rx_unit      = '0;
    logic [7:0]  rx_func      = '0;
    logic [8:0]  rx_delivered = '0;

    // transaction id as the stimulus expects it, to build matching frames
    logic [15:0] gen_txn = '0;

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int rx_hold        = 0;
    int fail_count     = 0;

    frame_item_t codec_in_queue[$];
    codec_out_t  codec_out_due[$];
    frame_item_t drive_item;
    frame_item_t seen_item;
    codec_out_t  want;

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    task automatic add_due(input out_kind_t k, input logic [7:0] b, input logic [7:0] u,
                           input logic [7:0] f, input status_t s, input logic [8:0] c,
                           input logic last);
        codec_out_t r;
        r.kind   = k;
        r.data   = b;
        r.unit   = u;
        r.func   = f;
        r.status = s;
        r.count  = c;
        r.last   = last;
        codec_out_due.push_back(r);
    endtask

    task automatic frame_codec_step(input frame_item_t it);
        logic [15:0] len;
        logic [8:0]  lim;
        logic [7:0]  hdr[8];
        status_t     st;
        int          i;
        case (it.kind)
            KIND_TX_START:
            begin
                if (!cfg_server && !it.rep)
                    txn_id = txn_id + 16'd1;
                if (it.plen > TX_PAYLOAD_MAX)
                    add_due(OUT_STATUS, 8'd0, 8'd0, 8'd0, ST_OVERFLOW, 9'd0, 1'b1);
                else
                begin
                    len = it.plen + 16'(LEN_OFFSET);
                    hdr = '{txn_id[15:8], txn_id[7:0], 8'd0, 8'd0, len[15:8], len[7:0],
                            it.unit, it.func};
                    for (i = 0; i < HDR_BYTES; i++)
                        add_due(OUT_TX_BYTE, hdr[i], 8'd0, 8'd0, ST_GOOD, 9'd0,
                                i == HDR_BYTES - 1);
                end
            end
            KIND_TX_BYTE:
                add_due(OUT_TX_BYTE, it.data, 8'd0, 8'd0, ST_GOOD, 9'd0, 1'b1);
            KIND_RX_BYTE:
            begin
                lim = (cfg_rx_limit > RX_LIMIT_MAX) ? RX_LIMIT_MAX : cfg_rx_limit;
                case (rx_count)
                    16'd0: rx_txn[15:8] = it.data;
                    16'd1: rx_txn[7:0] = it.data;
                    16'd2, 16'd3: if (it.data != 8'd0) rx_proto_bad = 1'b1;
                    16'd4: rx_len[15:8] = it.data;
                    16'd5: rx_len[7:0] = it.data;
                    16'd6: rx_unit = it.data;
                    16'd7: rx_func = it.data;
                    default:
                    begin
                        if (rx_delivered < lim)
                        begin
                            add_due(OUT_RX_BYTE, it.data, 8'd0, 8'd0, ST_GOOD, 9'd0, !it.fend);
                            rx_delivered = rx_delivered + 9'd1;
                        end
                    end
                endcase
                if (rx_count != 16'hFFFF)
                    rx_count = rx_count + 16'd1;
                if (it.fend)
                begin
                    if (rx_count < 16'(HDR_BYTES))
                        st = ST_SHORT;
                    else if (rx_proto_bad)
                        st = ST_PROTOCOL;
                    else if (rx_len != rx_count - 16'(COUNT_OFFSET))
                        st = ST_LENGTH;
                    else if (cfg_server)
                    begin
                        txn_id = rx_txn;
                        st = ST_GOOD;
                    end
                    else if (txn_id != rx_txn)
                        st = ST_ID;
                    else
                        st = ST_GOOD;
                    if (st == ST_GOOD)
                        add_due(OUT_STATUS, 8'd0, rx_unit, rx_func, ST_GOOD, rx_delivered, 1'b1);
                    else
                        add_due(OUT_STATUS, 8'd0, 8'd0, 8'd0, st, 9'd0, 1'b1);
                    rx_count     = '0;
                    rx_txn       = '0;
                    rx_len       = '0;
                    rx_proto_bad = 1'b0;
                    rx_unit      = '0;
                    rx_func      = '0;
                    rx_delivered = '0;
                end
            end
            default:
            begin
            end
        endcase
    endtask

    task automatic check_field(input string name, input logic [15:0] exp_v,
                               input logic [15:0] got_v);
        if (got_v !== exp_v)
        begin
            $error("%s mismatch: expected %0d, actual %0d", name, exp_v, got_v);
            fail_count++;
        end
    endtask

    // driver
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (!item_ch.valid || item_ch.ready)
            begin
                if (codec_in_queue.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    drive_item = codec_in_queue.pop_front();
                    item_ch.valid          <= 1'b1;
                    item_ch.kind           <= drive_item.kind;
                    item_ch.unit_id        <= drive_item.unit;
                    item_ch.function_code  <= drive_item.func;
                    item_ch.payload_length <= drive_item.plen;
                    item_ch.repeat_request <= drive_item.rep;
                    item_ch.data_byte      <= drive_item.data;
                    item_ch.frame_end      <= drive_item.fend;
                end
                else
                    item_ch.valid <= 1'b0;
            end
        end
    end

    // result ready, with long hold-off when requested
    always @(posedge clk)
    begin
        if (rx_hold != 0)
        begin
            result_ch.ready <= 1'b0;
            rx_hold <= rx_hold - 1;
        end
        else
            result_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // monitor
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (item_ch.valid && item_ch.ready)
            begin
                seen_item.kind = item_ch.kind;
                seen_item.unit = item_ch.unit_id;
                seen_item.func = item_ch.function_code;
                seen_item.plen = item_ch.payload_length;
                seen_item.rep  = item_ch.repeat_request;
                seen_item.data = item_ch.data_byte;
                seen_item.fend = item_ch.frame_end;
                frame_codec_step(seen_item);
            end
            if (result_ch.valid && result_ch.ready)
            begin
                if (codec_out_due.size() == 0)
                begin
                    $error("unexpected result item: out_kind %0d out_byte %0d status %0d",
                           result_ch.out_kind, result_ch.out_byte, result_ch.status);
                    fail_count++;
                end
                else
                begin
                    want = codec_out_due.pop_front();
                    check_field("out_kind", want.kind, result_ch.out_kind);
                    check_field("out_byte", want.data, result_ch.out_byte);
                    check_field("rx_unit", want.unit, result_ch.rx_unit);
                    check_field("rx_function", want.func, result_ch.rx_function);
                    check_field("status", want.status, result_ch.status);
                    check_field("delivered_count", want.count, result_ch.delivered_count);
                    check_field("run_last", want.last, result_ch.run_last);
                end
            end
        end
    end

    task automatic push_item(input logic [1:0] kind, input logic [7:0] unit,
                             input logic [7:0] func, input logic [15:0] plen, input logic rep,
                             input logic [7:0] data, input logic fend);
        frame_item_t it;
        it.kind = kind;
        it.unit = unit;
        it.func = func;
        it.plen = plen;
        it.rep  = rep;
        it.data = data;
        it.fend = fend;
        codec_in_queue.push_back(it);
    endtask

    task automatic push_rx(input logic [7:0] data, input logic fend);
        push_item(KIND_RX_BYTE, 8'($urandom), 8'($urandom), 16'($urandom), 1'($urandom),
                  data, fend);
    endtask

    task automatic queue_tx_start(input logic [7:0] unit, input logic [7:0] func,
                                  input logic [15:0] plen, input logic rep, input bit with_pay);
        int i;
        push_item(KIND_TX_START, unit, func, plen, rep, 8'($urandom), 1'($urandom));
        if (!cfg_server && !rep)
            gen_txn = gen_txn + 16'd1;
        if (with_pay && plen <= TX_PAYLOAD_MAX)
            for (i = 0; i < plen; i++)
                push_item(KIND_TX_BYTE, 8'($urandom), 8'($urandom), 16'($urandom),
                          1'($urandom), 8'($urandom), 1'($urandom));
    endtask

    task automatic queue_frame(input frame_flaw_t flaw, input int pay_n);
        logic [15:0] id;
        logic [15:0] len_field;
        logic [7:0]  hdr[8];
        int          total;
        int          i;
        if (flaw == FLAW_SHORT)
        begin
            total = $urandom_range(1, HDR_BYTES - 1);
            for (i = 0; i < total; i++)
                push_rx(8'($urandom), i == total - 1);
        end
        else
        begin
            total = HDR_BYTES + pay_n;
            id = cfg_server ? 16'($urandom) : gen_txn;
            if (flaw == FLAW_ID)
                id = id + 16'($urandom_range(1, 65535));
            if (cfg_server && (flaw == FLAW_NONE || flaw == FLAW_ID))
                gen_txn = id;
            // long frames compare against the saturated byte count
            len_field = 16'(((total > 65535) ? 65535 : total) - COUNT_OFFSET);
            if (flaw == FLAW_LENGTH)
                len_field = len_field + 16'($urandom_range(1, 65535));
            hdr = '{id[15:8], id[7:0], 8'd0, 8'd0, len_field[15:8], len_field[7:0],
                    8'($urandom), 8'($urandom)};
            if (flaw == FLAW_PROTOCOL)
                hdr[2 + $urandom_range(1)] = 8'($urandom_range(1, 255));
            for (i = 0; i < total; i++)
                push_rx((i < HDR_BYTES) ? hdr[i] : 8'($urandom), i == total - 1);
        end
    endtask

    task automatic random_traffic(input int n_items);
        int          done_cnt;
        int          start_size;
        int          pick;
        int          r;
        frame_flaw_t flaw;
        done_cnt = 0;
        while (done_cnt < n_items)
        begin
            start_size = codec_in_queue.size();
            pick = $urandom_range(99);
            if (pick < 45)
            begin
                r = $urandom_range(99);
                flaw = (r < 60) ? FLAW_NONE : (r < 70) ? FLAW_SHORT :
                       (r < 80) ? FLAW_PROTOCOL : (r < 90) ? FLAW_LENGTH : FLAW_ID;
                queue_frame(flaw, ($urandom_range(99) < 3) ? $urandom_range(250, 300)
                                                           : $urandom_range(0, 6));
            end
            else if (pick < 70)
                queue_tx_start(8'($urandom), 8'($urandom),
                               ($urandom_range(99) < 10) ? 16'($urandom_range(257, 65535))
                                                         : 16'($urandom_range(0, 8)),
                               $urandom_range(99) < 20, 1'b1);
            else if (pick < 85)
                push_item(KIND_TX_BYTE, 8'($urandom), 8'($urandom), 16'($urandom),
                          1'($urandom), 8'($urandom), 1'($urandom));
            else if (pick < 92)
                push_rx(8'($urandom), 1'($urandom));
            else
                push_item(KIND_UNUSED, 8'($urandom), 8'($urandom), 16'($urandom),
                          1'($urandom), 8'($urandom), 1'($urandom));
            if (pick < 92)
                done_cnt += codec_in_queue.size() - start_size;
        end
    endtask

    task automatic settle();
        while (codec_in_queue.size() != 0 || item_ch.valid || codec_out_due.size() != 0)
            @(negedge clk);
        repeat (8) @(negedge clk);
    endtask

    task automatic write_reg(input cfg_index_t idx, input logic [8:0] val);
        @(posedge clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= val;
        do
            @(posedge clk);
        while (cfg_ch.ready !== 1'b1);
        cfg_ch.valid <= 1'b0;
        if (idx == CFG_SERVER_MODE)
            cfg_server = val[0];
        else
            cfg_rx_limit = val;
        @(negedge clk);
    endtask

    task automatic set_mode(input logic server, input logic [8:0] limit);
        settle();
        write_reg(CFG_SERVER_MODE, {8'($urandom), server});
        write_reg(CFG_MAX_RX_PAYLOAD, limit);
    endtask

    initial
    begin
        item_ch.valid          = 1'b0;
        item_ch.kind           = KIND_TX_START;
        item_ch.unit_id        = '0;
        item_ch.function_code  = '0;
        item_ch.payload_length = '0;
        item_ch.repeat_request = 1'b0;
        item_ch.data_byte      = '0;
        item_ch.frame_end      = 1'b0;
        cfg_ch.valid           = 1'b0;
        cfg_ch.index           = CFG_SERVER_MODE;
        cfg_ch.data            = '0;
        result_ch.ready        = 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed: header extremes, overflow, pass-through, unused kind, short, good and protocol-error frames
        queue_tx_start(8'd0, 8'd0, 16'd0, 1'b0, 1'b0);
        queue_tx_start(8'hFF, 8'hFF, TX_PAYLOAD_MAX, 1'b1, 1'b0);
        queue_tx_start(8'($urandom), 8'($urandom), TX_PAYLOAD_MAX + 16'd1, 1'b0, 1'b0);
        queue_tx_start(8'($urandom), 8'($urandom), 16'hFFFF, 1'b0, 1'b0);
        push_item(KIND_TX_BYTE, 8'd0, 8'd0, 16'd0, 1'b0, 8'h00, 1'b0);
        push_item(KIND_TX_BYTE, 8'hFF, 8'hFF, 16'hFFFF, 1'b1, 8'hFF, 1'b1);
        push_item(KIND_UNUSED, 8'hFF, 8'hFF, 16'hFFFF, 1'b1, 8'hFF, 1'b1);
        queue_frame(FLAW_SHORT, 0);
        queue_frame(FLAW_NONE, 0);
        queue_frame(FLAW_PROTOCOL, 0);

        set_mode(1'b0, 9'd256);
        random_traffic(40);
        queue_frame(FLAW_NONE, 260);

        set_mode(1'b1, 9'd5);
        send_idle_pct = 53;
        random_traffic(40);

        set_mode(1'b0, 9'd0);
        send_idle_pct  = 0;
        recv_stall_pct = 53;
        random_traffic(40);

        set_mode(1'b1, 9'd511);
        send_idle_pct  = 23;
        recv_stall_pct = 23;
        random_traffic(40);

        set_mode(1'b0, 9'd1);
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        rx_hold = 300;
        random_traffic(40);
        settle();
        random_traffic(20);

        settle();
        if (fail_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    initial
    begin
        #20_000_000;
        $display("Verification failed");
        $finish;
    end

endmodule
